@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lcdseq_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, constants and the bus step generator of the LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	localparam int unsigned WAIT_W        = 15;
	localparam int unsigned STEP_W        = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE    = 2'd2;

	localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
	localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0C;
	localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h02;

	localparam logic [WAIT_W-1:0] WAIT_POWERUP    = 15'd20000;
	localparam logic [WAIT_W-1:0] WAIT_INIT_LONG  = 15'd7000;
	localparam logic [WAIT_W-1:0] WAIT_INIT_SHORT = 15'd100;
	localparam logic [WAIT_W-1:0] WAIT_BYTE       = 15'd40;
	localparam logic [WAIT_W-1:0] WAIT_SLOW       = 15'd1640;
	localparam logic [WAIT_W-1:0] WAIT_NONE       = 15'd0;

	localparam logic [3:0] NIB_WAKE = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

	localparam logic [STEP_W-1:0] LAST_INIT  = 4'd14;
	localparam logic [STEP_W-1:0] LAST_BYTE  = 4'd1;
	localparam logic [STEP_W-1:0] LAST_WRAP  = 4'd3;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_CMD    = 2'd1,
		OP_DATA   = 2'd2,
		OP_CURSOR = 2'd3
	} op_t;

	// One classified request, as queued between front and back.
	typedef struct packed {
		op_t               op;
		logic [7:0]        data_byte;
		logic [7:0]        pos_byte;
		logic [7:0]        old_col;
		logic              old_row;
		logic [7:0]        new_col;
		logic              new_row;
		logic [STEP_W-1:0] last_idx;
	} job_t;

	// One bus step as it leaves the block.
	typedef struct packed {
		logic              strobe;
		logic              rs;
		logic [3:0]        nibble;
		logic [WAIT_W-1:0] wait_us;
		logic              last;
		logic [7:0]        col;
		logic              row;
	} step_t;

	typedef struct packed {
		logic [7:0] function_set;
		logic [7:0] display_ctrl;
		logic [7:0] entry_mode;
	} cfg_t;

	function automatic logic [7:0] position_cmd(logic [7:0] col, logic row);
		return {1'b1, row, 2'b00, col[3:0]};
	endfunction

	function automatic step_t step_gen(job_t j, logic [STEP_W-1:0] s, cfg_t cfg);
		step_t      st;
		logic [7:0] b;
		logic       lo;
		st.strobe  = 1'b1;
		st.rs      = 1'b0;
		st.nibble  = 4'h0;
		st.wait_us = WAIT_NONE;
		st.last    = (s == j.last_idx);
		// data step 0 shows the old cursor, step 1 the new column on the old row
		st.col     = (s == '0) ? j.old_col : j.new_col;
		st.row     = (s < STEP_W'(2)) ? j.old_row : j.new_row;
		b          = j.data_byte;
		lo         = s[0];
		case (j.op)
			OP_INIT: begin
				lo = ~s[0];
				case (s) inside
					4'd0: begin
						st.strobe  = 1'b0;
						st.wait_us = WAIT_POWERUP;
					end
					4'd1, 4'd3: begin
						st.nibble  = NIB_WAKE;
						st.wait_us = WAIT_INIT_LONG;
					end
					4'd2: begin
						st.nibble  = NIB_WAKE;
						st.wait_us = WAIT_INIT_SHORT;
					end
					4'd4: begin
						st.nibble  = NIB_FOUR_BIT;
						st.wait_us = WAIT_BYTE;
					end
					default: begin
						case (s) inside
							[4'd5:4'd6]:   b = cfg.function_set;
							[4'd7:4'd8]:   b = cfg.display_ctrl;
							[4'd9:4'd10]:  b = CMD_CLEAR;
							[4'd11:4'd12]: b = cfg.entry_mode;
							default:       b = CMD_HOME;
						endcase
						st.nibble = lo ? b[3:0] : b[7:4];
						if (!lo) begin
							st.wait_us = WAIT_NONE;
						end else if (s == 4'd10 || s == 4'd14) begin
							st.wait_us = WAIT_SLOW;
						end else begin
							st.wait_us = WAIT_BYTE;
						end
					end
				endcase
			end
			OP_CMD: begin
				st.nibble  = lo ? b[3:0] : b[7:4];
				st.wait_us = lo ? WAIT_BYTE : WAIT_NONE;
			end
			OP_CURSOR: begin
				b          = j.pos_byte;
				st.nibble  = lo ? b[3:0] : b[7:4];
				st.wait_us = lo ? WAIT_BYTE : WAIT_NONE;
			end
			OP_DATA: begin
				// steps 2 and 3 carry the position command after a row wrap
				b          = s[1] ? j.pos_byte : j.data_byte;
				st.rs      = ~s[1];
				st.nibble  = lo ? b[3:0] : b[7:4];
				st.wait_us = lo ? WAIT_BYTE : WAIT_NONE;
			end
			default: begin
				st.strobe = 1'b0;
			end
		endcase
		return st;
	endfunction

endpackage

@@ hw/rtl/lcdseq_front.sv @@
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts requests, keeps the cursor and classifies each request into a job.
// ----------------------------------------------------------------------------
module lcdseq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [7:0]           byte_value,
	input  logic [7:0]           column,
	input  logic                 row,
	input  logic                 q_full,
	output logic                 push,
	output lcdseq_pkg::job_t     push_job
);
	import lcdseq_pkg::*;

	logic [7:0] col_q;
	logic       row_q;
	logic [7:0] col_inc;
	logic       wrap;
	op_t        op;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign op       = op_t'(opcode);
	assign col_inc  = col_q + 8'd1;
	assign wrap     = (col_inc[3:0] == 4'h0);

	always_comb begin
		push_job.op        = op;
		push_job.data_byte = byte_value;
		push_job.old_col   = col_q;
		push_job.old_row   = row_q;
		push_job.new_col   = col_q;
		push_job.new_row   = row_q;
		push_job.last_idx  = LAST_BYTE;
		case (op)
			OP_INIT: begin
				push_job.last_idx = LAST_INIT;
			end
			OP_CURSOR: begin
				// both steps show the cursor just set
				push_job.old_col = column;
				push_job.old_row = row ^ column[4];
				push_job.new_col = column;
				push_job.new_row = row ^ column[4];
			end
			OP_DATA: begin
				push_job.new_col = col_inc;
				push_job.new_row = row_q ^ wrap;
				if (wrap) begin
					push_job.last_idx = LAST_WRAP;
				end
			end
			default: begin
				push_job.last_idx = LAST_BYTE;
			end
		endcase
		push_job.pos_byte = position_cmd(push_job.new_col, push_job.new_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 1'b0;
		end else if (push) begin
			col_q <= push_job.new_col;
			row_q <= push_job.new_row;
		end
	end

endmodule

@@ hw/rtl/lcdseq_queue.sv @@
// ----------------------------------------------------------------------------
// lcdseq_queue
// Short job queue between the request front and the step back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdseq_queue #(
	parameter int unsigned DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcdseq_pkg::job_t     push_job,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output lcdseq_pkg::job_t     head
);
	import lcdseq_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_push_full, !(push && full), "job pushed into a full queue")
	`ASSERT_ALWAYS(a_no_pop_empty, !(pop && !head_valid), "job popped from an empty queue")
	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

@@ hw/rtl/lcdseq_back.sv @@
// ----------------------------------------------------------------------------
// lcdseq_back
// Walks the steps of the head job and holds each step in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdseq_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  lcdseq_pkg::job_t     head,
	output logic                 pop,
	input  lcdseq_pkg::cfg_t     cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lcdseq_pkg::step_t    out_step
);
	import lcdseq_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	step_t             out_step_q;
	logic              load;
	logic              at_last;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign at_last   = (step_q == head.last_idx);
	assign pop       = load && at_last;
	assign out_valid = out_valid_q;
	assign out_step  = out_step_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_step_q <= step_gen(head, step_q, cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// advance within the job, restart on the next one
			if (load) begin
				step_q <= at_last ? '0 : step_q + 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_idle_step_zero, head_valid || step_q == '0,
		"step index left mid-job with no job queued")
	`ASSERT_ALWAYS(a_step_in_job, !head_valid || step_q <= head.last_idx,
		"step index past the last step of the job")
	`ASSERT_NEXT(a_last_flag, pop, out_valid_q && out_step_q.last,
		"final step of a job not flagged as last")

endmodule

@@ hw/rtl/char_lcd_nibble_write_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core
// Four-bit character LCD write sequencer: requests in, nibble bus steps out.
// ----------------------------------------------------------------------------
// One bus step leaves per clock while out_ready is high and a job is queued. A
// command byte or set cursor has 2 steps, a data character 2 or 4 (4 when the
// column wraps to a new row), and init 15. The front end sets the step count of
// each job and the step walker in the back end walks it. Requests are taken at
// one per clock as long as the job queue (QUEUE_DEPTH entries) has room, and
// the first step of a request is held in the output register once the request
// has reached the queue head and the output register is free. Configuration
// registers are read while init runs, so write them only when the block is idle.
module char_lcd_nibble_write_sequencer_core #(
	parameter int unsigned QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcdseq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [7:0]                          byte_value,
	input  logic [7:0]                          column,
	input  logic                                row,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                strobe_res,
	output logic                                rs_level,
	output logic [3:0]                          nibble,
	output logic [lcdseq_pkg::WAIT_W-1:0]       wait_us,
	output logic                                last,
	output logic [7:0]                          cursor_column,
	output logic                                cursor_row
);
	import lcdseq_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  push;
	job_t  push_job;
	logic  pop;
	logic  head_valid;
	job_t  head;
	step_t out_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.function_set <= FUNCTION_SET_RST;
			cfg_q.display_ctrl <= DISPLAY_CTRL_RST;
			cfg_q.entry_mode   <= ENTRY_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FUNCTION_SET: cfg_q.function_set <= cfg_data;
				CFG_DISPLAY_CTRL: cfg_q.display_ctrl <= cfg_data;
				CFG_ENTRY_MODE:   cfg_q.entry_mode   <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	lcdseq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.byte_value (byte_value),
		.column     (column),
		.row        (row),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	lcdseq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lcdseq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_step   (out_step)
	);

	assign strobe_res    = out_step.strobe;
	assign rs_level      = out_step.rs;
	assign nibble        = out_step.nibble;
	assign wait_us       = out_step.wait_us;
	assign last          = out_step.last;
	assign cursor_column = out_step.col;
	assign cursor_row    = out_step.row;

endmodule
